/* design/lcd4_pkg.sv */
// ----------------------------------------------------------------------------
// lcd4_pkg: shared types and microcode for the 4-bit character LCD controller
// Item formats, screen geometry, bus command bytes and the control store.
// ----------------------------------------------------------------------------
package lcd4_pkg;

	// screen geometry
	localparam int COLUMNS = 16;
	localparam int ROWS    = 2;
	localparam int DEPTH   = ROWS * COLUMNS;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
	// column compare width: holds the 4-bit column plus one and COLUMNS itself
	localparam int COLX_W  = ((COL_W > 4) ? COL_W : 4) + 1;

	// decimal split of an 8-bit value: quotient fits five bits
	localparam int QUO_W      = 5;
	localparam int RECIP_MUL  = 205;
	localparam int RECIP_SHFT = 11;

	// bus bytes
	localparam logic [7:0] ROW0_POS    = 8'h80;
	localparam logic [7:0] ROW1_POS    = 8'hC0;
	localparam logic [7:0] CMD_HOME    = 8'h02;
	localparam logic [7:0] NIB_WAKE    = 8'h30;
	localparam logic [7:0] NIB_4BIT    = 8'h20;
	localparam logic [7:0] CMD_FUNC    = 8'h2C;
	localparam logic [7:0] CMD_DISP_ON = 8'h0C;
	localparam logic [7:0] CMD_CLEAR   = 8'h01;
	localparam logic [7:0] ASCII_ZERO  = 8'h30;

	// request codes
	localparam logic [2:0] MODE_INIT    = 3'd0;
	localparam logic [2:0] MODE_PUTC    = 3'd1;
	localparam logic [2:0] MODE_PUTN    = 3'd2;
	localparam logic [2:0] MODE_REFRESH = 3'd3;
	localparam logic [2:0] MODE_CLEAR   = 3'd4;

	typedef struct packed {
		logic [2:0] mode;
		logic [3:0] column;
		logic       row;
		logic [7:0] value;
	} cmd_t;

	typedef struct packed {
		logic       is_data;
		logic [7:0] bus_byte;
		logic       upper_only;
		logic [4:0] wait_ms;
		logic       last;
	} xfer_t;

	// control store
	localparam int PC_W = 5;

	typedef enum logic [1:0] {
		BS_CONST,
		BS_ROW,
		BS_CELL
	} bsel_t;

	typedef enum logic [2:0] {
		DP_NONE,
		DP_SPLIT,
		DP_WR_CHAR,
		DP_WR_TENS,
		DP_WR_ONES,
		DP_ROW_START,
		DP_CELL
	} dp_t;

	typedef enum logic [1:0] {
		SQ_NEXT,
		SQ_GOTO,
		SQ_END,
		SQ_SCAN
	} seq_t;

	typedef struct packed {
		logic            emit;
		bsel_t           bsel;
		logic            is_data;
		logic            upper_only;
		logic [4:0]      wait_ms;
		logic [7:0]      bus_byte;
		logic            last;
		dp_t             dp;
		seq_t            seq;
		logic [PC_W-1:0] target;
	} ucode_t;

	// entry points and fixed steps
	localparam logic [PC_W-1:0] ST_INIT    = 5'd0;
	localparam logic [PC_W-1:0] ST_PUTC    = 5'd7;
	localparam logic [PC_W-1:0] ST_PUTN    = 5'd8;
	localparam logic [PC_W-1:0] ST_CLEAR   = 5'd11;
	localparam logic [PC_W-1:0] ST_REFRESH = 5'd13;
	localparam logic [PC_W-1:0] ST_ROW     = 5'd14;
	localparam logic [PC_W-1:0] ST_CELL    = 5'd15;
	localparam logic [PC_W-1:0] ST_NOP     = 5'd16;

	function automatic ucode_t emit_word(input logic [7:0] b, input logic upper,
			input logic [4:0] w, input seq_t s);
		ucode_t uc;
		uc            = '0;
		uc.emit       = 1'b1;
		uc.bsel       = BS_CONST;
		uc.bus_byte   = b;
		uc.upper_only = upper;
		uc.wait_ms    = w;
		uc.dp         = DP_NONE;
		uc.seq        = s;
		uc.target     = ST_NOP;
		return uc;
	endfunction

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t uc;
		uc        = '0;
		uc.bsel   = BS_CONST;
		uc.dp     = DP_NONE;
		uc.seq    = SQ_END;
		uc.target = ST_NOP;
		unique case (pc)
			5'd0: uc = emit_word(NIB_WAKE, 1'b1, 5'd30, SQ_NEXT);
			5'd1: uc = emit_word(NIB_WAKE, 1'b1, 5'd6, SQ_NEXT);
			5'd2: uc = emit_word(NIB_WAKE, 1'b1, 5'd1, SQ_NEXT);
			5'd3: uc = emit_word(NIB_4BIT, 1'b1, 5'd2, SQ_NEXT);
			5'd4: uc = emit_word(CMD_FUNC, 1'b0, 5'd3, SQ_NEXT);
			5'd5: uc = emit_word(CMD_DISP_ON, 1'b0, 5'd1, SQ_NEXT);
			5'd6: begin
				uc      = emit_word(CMD_CLEAR, 1'b0, 5'd1, SQ_END);
				uc.last = 1'b1;
			end
			ST_PUTC: begin
				uc.dp  = DP_WR_CHAR;
				uc.seq = SQ_END;
			end
			ST_PUTN: begin
				uc.dp  = DP_SPLIT;
				uc.seq = SQ_NEXT;
			end
			5'd9: begin
				uc.dp  = DP_WR_TENS;
				uc.seq = SQ_NEXT;
			end
			5'd10: begin
				uc.dp  = DP_WR_ONES;
				uc.seq = SQ_END;
			end
			ST_CLEAR: uc = emit_word(CMD_CLEAR, 1'b0, 5'd1, SQ_NEXT);
			5'd12: begin
				uc        = emit_word(CMD_HOME, 1'b0, 5'd3, SQ_GOTO);
				uc.target = ST_ROW;
			end
			ST_REFRESH: uc = emit_word(CMD_HOME, 1'b0, 5'd1, SQ_NEXT);
			ST_ROW: begin
				uc      = emit_word(8'h00, 1'b0, 5'd1, SQ_NEXT);
				uc.bsel = BS_ROW;
				uc.dp   = DP_ROW_START;
			end
			ST_CELL: begin
				uc         = emit_word(8'h00, 1'b0, 5'd1, SQ_SCAN);
				uc.bsel    = BS_CELL;
				uc.is_data = 1'b1;
				uc.dp      = DP_CELL;
				uc.target  = ST_ROW;
			end
			default: uc.seq = SQ_END;
		endcase
		return uc;
	endfunction

endpackage

/* design/lcd4_ram.sv */
// ----------------------------------------------------------------------------
// lcd4_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when disabled.
// ----------------------------------------------------------------------------
module lcd4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* design/char_lcd_four_bit_controller.sv */
// ----------------------------------------------------------------------------
// char_lcd_four_bit_controller: 4-bit character LCD request sequencer
// Keeps the screen buffer, writes put requests into it and turns the other requests into LCD bus transfers.
// ----------------------------------------------------------------------------
//
//  channel | signals                        | accepted when
//  --------+--------------------------------+------------------------------
//  cmd     | cmd_valid, cmd_stall, cmd      | cmd_valid && !cmd_stall
//  xfer    | xfer_valid, xfer_stall, xfer   | xfer_valid && !xfer_stall
//  cfg     | cfg_valid, cfg_ready, cfg_data | cfg_valid && cfg_ready
//
// One request item at a time: cmd_stall is high from acceptance until the
// microcode program for that item ends. The program steps once per cycle
// while it does not wait for the output slot and emits at most one transfer
// per step. The single output register sets the pace: a step that emits
// waits while the previous transfer is still stalled.
// Reset zeroes the screen at once through per-entry valid bits; no sweep.
//
module char_lcd_four_bit_controller (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  lcd4_pkg::cmd_t  cmd,
	output logic            xfer_valid,
	input  logic            xfer_stall,
	output lcd4_pkg::xfer_t xfer,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [7:0]      cfg_data
);

	// sequencer state
	logic                          busy_q;
	logic [lcd4_pkg::PC_W-1:0]     pc_q;
	logic [lcd4_pkg::PC_W-1:0]     entry_pc;
	lcd4_pkg::ucode_t              uc;
	logic                          adv;
	logic                          slot_free;

	// latched request item
	logic [3:0]                    col_q;
	logic                          row_q;
	logic [7:0]                    value_q;
	logic [lcd4_pkg::QUO_W-1:0]    quo_q;
	logic [15:0]                   quo_prod;

	// refresh scan counters
	logic [lcd4_pkg::ROW_W-1:0]    rcnt_q;
	logic [lcd4_pkg::COL_W-1:0]    ccnt_q;
	logic [lcd4_pkg::ADDR_W-1:0]   addr_q;
	logic                          last_col;
	logic                          last_row;

	// screen buffer ports
	logic [lcd4_pkg::DEPTH-1:0]    vld_q;
	logic                          cellv_q;
	logic                          wr_sel;
	logic                          wr_en;
	logic [lcd4_pkg::COLX_W-1:0]   wr_col;
	logic [lcd4_pkg::ADDR_W-1:0]   wr_addr;
	logic [7:0]                    wr_data;
	logic                          row_ok;
	logic                          rd_en;
	logic [lcd4_pkg::ADDR_W-1:0]   rd_addr;
	logic [7:0]                    rd_data;
	logic [7:0]                    cell_byte;

	// digit split
	logic [7:0]                    quo_x;
	logic [7:0]                    ones;

	// output stage and config
	logic                          xfer_valid_q;
	lcd4_pkg::xfer_t               xfer_q;
	lcd4_pkg::xfer_t               xfer_d;
	logic [7:0]                    enable_pulse_ms_q;

	function automatic logic [lcd4_pkg::ADDR_W-1:0] row_base(input logic r);
		return r ? lcd4_pkg::ADDR_W'(lcd4_pkg::COLUMNS) : '0;
	endfunction

	// control store fetch and handshake
	assign uc        = lcd4_pkg::ucode_rom(pc_q);
	assign slot_free = !xfer_valid_q || !xfer_stall;
	// emitting steps wait for the output slot; buffer steps never stall
	assign adv       = busy_q && (!uc.emit || slot_free);
	assign cmd_stall = busy_q;
	assign cfg_ready = 1'b1;

	// dispatch: each defined request code starts its own routine; others go to the no-op step
	always_comb begin
		unique case (cmd.mode)
			lcd4_pkg::MODE_INIT:    entry_pc = lcd4_pkg::ST_INIT;
			lcd4_pkg::MODE_PUTC:    entry_pc = lcd4_pkg::ST_PUTC;
			lcd4_pkg::MODE_PUTN:    entry_pc = lcd4_pkg::ST_PUTN;
			lcd4_pkg::MODE_REFRESH: entry_pc = lcd4_pkg::ST_REFRESH;
			lcd4_pkg::MODE_CLEAR:   entry_pc = lcd4_pkg::ST_CLEAR;
			default:                entry_pc = lcd4_pkg::ST_NOP;
		endcase
	end

	assign last_col = ccnt_q == lcd4_pkg::COL_W'(lcd4_pkg::COLUMNS - 1);
	assign last_row = rcnt_q == lcd4_pkg::ROW_W'(lcd4_pkg::ROWS - 1);

	// tens by reciprocal multiply; ones from the registered tens in a later step
	assign quo_prod = {8'h00, value_q} * 16'(lcd4_pkg::RECIP_MUL);
	assign quo_x    = {{(8 - lcd4_pkg::QUO_W){1'b0}}, quo_q};
	assign ones     = value_q - ((quo_x << 3) + (quo_x << 1));

	// buffer write: drop any byte past the last column or row
	always_comb begin
		wr_sel  = 1'b0;
		wr_col  = lcd4_pkg::COLX_W'(col_q);
		wr_data = value_q;
		case (uc.dp)
			lcd4_pkg::DP_WR_CHAR: begin
				wr_sel = 1'b1;
			end
			lcd4_pkg::DP_WR_TENS: begin
				wr_sel  = 1'b1;
				wr_data = lcd4_pkg::ASCII_ZERO + quo_x;
			end
			lcd4_pkg::DP_WR_ONES: begin
				wr_sel  = 1'b1;
				wr_col  = lcd4_pkg::COLX_W'(col_q) + lcd4_pkg::COLX_W'(1);
				wr_data = lcd4_pkg::ASCII_ZERO + ones;
			end
			default: wr_sel = 1'b0;
		endcase
	end

	assign row_ok  = {1'b0, row_q} < 2'(lcd4_pkg::ROWS);
	assign wr_en   = adv && wr_sel && row_ok && (wr_col < lcd4_pkg::COLX_W'(lcd4_pkg::COLUMNS));
	assign wr_addr = row_base(row_q) + lcd4_pkg::ADDR_W'(wr_col);

	// buffer read runs one step ahead of the cell transfer that shows it
	assign rd_addr = (uc.dp == lcd4_pkg::DP_ROW_START) ? row_base(rcnt_q != '0)
		: addr_q + lcd4_pkg::ADDR_W'(1);
	assign rd_en   = adv && ((uc.dp == lcd4_pkg::DP_ROW_START)
		|| (uc.dp == lcd4_pkg::DP_CELL && !last_col));

	lcd4_ram #(
		.WIDTH(8),
		.DEPTH(lcd4_pkg::DEPTH)
	) u_screen (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// never-written entries read as the reset value, zero
	assign cell_byte = cellv_q ? rd_data : 8'h00;

	// transfer word built from the current control word
	always_comb begin
		xfer_d.is_data    = uc.is_data;
		xfer_d.upper_only = uc.upper_only;
		xfer_d.wait_ms    = uc.wait_ms;
		xfer_d.last       = uc.last || (uc.seq == lcd4_pkg::SQ_SCAN && last_col && last_row);
		case (uc.bsel)
			lcd4_pkg::BS_ROW:  xfer_d.bus_byte = (rcnt_q == '0) ? lcd4_pkg::ROW0_POS
				: lcd4_pkg::ROW1_POS;
			lcd4_pkg::BS_CELL: xfer_d.bus_byte = cell_byte;
			default:           xfer_d.bus_byte = uc.bus_byte;
		endcase
	end

	// sequencer control, valid bits, output valid and the config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q            <= 1'b0;
			pc_q              <= lcd4_pkg::ST_NOP;
			rcnt_q            <= '0;
			ccnt_q            <= '0;
			addr_q            <= '0;
			vld_q             <= '0;
			cellv_q           <= 1'b0;
			xfer_valid_q      <= 1'b0;
			enable_pulse_ms_q <= 8'd1;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				busy_q <= 1'b1;
				pc_q   <= entry_pc;
				rcnt_q <= '0;
			end else if (adv) begin
				case (uc.seq)
					lcd4_pkg::SQ_NEXT: pc_q <= pc_q + lcd4_pkg::PC_W'(1);
					lcd4_pkg::SQ_GOTO: pc_q <= uc.target;
					lcd4_pkg::SQ_SCAN: begin
						// advance column, then row, then finish
						if (!last_col) begin
							ccnt_q <= ccnt_q + lcd4_pkg::COL_W'(1);
						end else if (!last_row) begin
							rcnt_q <= rcnt_q + lcd4_pkg::ROW_W'(1);
							pc_q   <= uc.target;
						end else begin
							busy_q <= 1'b0;
						end
					end
					default: busy_q <= 1'b0;
				endcase
				if (uc.dp == lcd4_pkg::DP_ROW_START) begin
					ccnt_q <= '0;
				end
			end
			if (rd_en) begin
				addr_q  <= rd_addr;
				cellv_q <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (adv && uc.emit) begin
				xfer_valid_q <= 1'b1;
			end else if (!xfer_stall) begin
				xfer_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				enable_pulse_ms_q <= cfg_data;
			end
		end
	end

	// item and result payload: hold unless loaded
	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			col_q   <= cmd.column;
			row_q   <= cmd.row;
			value_q <= cmd.value;
		end
		if (adv && uc.dp == lcd4_pkg::DP_SPLIT) begin
			quo_q <= quo_prod[lcd4_pkg::RECIP_SHFT +: lcd4_pkg::QUO_W];
		end
		if (adv && uc.emit) begin
			xfer_q <= xfer_d;
		end
	end

	assign xfer_valid = xfer_valid_q;
	assign xfer       = xfer_q;

`ifndef ASSERT_OFF
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (int'(ccnt_q) < lcd4_pkg::COLUMNS))
		else $error("scan column counter past the last column");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (int'(wr_addr) < lcd4_pkg::DEPTH))
		else $error("buffer write outside the screen");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && uc.emit) |-> slot_free)
		else $error("transfer emitted over a stalled transfer");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> (busy_q && !$past(busy_q)))
		else $error("accepted item did not start a program");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (enable_pulse_ms_q == $past(cfg_data)))
		else $error("enable pulse register not written");
`endif

endmodule
